// ----- rtl/ultrasonic_range_seven_segment_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ultrasonic ranging core
// Each macro expands to a labeled concurrent assertion, or to nothing when
// assertions are compiled out.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_SEVEN_SEGMENT_CORE_ASSERT_SVH
`define ULTRASONIC_RANGE_SEVEN_SEGMENT_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property holds at every clock edge outside reset
`define URSS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ultrasonic ranging core: assertion failed");

// Antecedent implies consequent at the next clock edge
`define URSS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ultrasonic ranging core: next-cycle assertion failed");

`else

`define URSS_ASSERT(lbl, clk, rst, prop)
`define URSS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/urss_pkg.sv -----
// ----------------------------------------------------------------------------
// urss_pkg
// Shared types, constants and the segment table of the ultrasonic ranging core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package urss_pkg;

  // Widths fixed by the interface
  localparam int TICK_BITS      = 10;
  localparam int DIST_BITS      = 10;
  localparam int SEG_BITS       = 8;
  localparam int DIGITS         = 4;
  localparam int CFG_INDEX_BITS = 1;

  // Default echo counter width
  localparam int COUNT_BITS_DEF = 12;

  // Register reset values
  localparam logic [TICK_BITS-1:0] TRIGGER_TICKS_RST = 10'd100;
  localparam logic [TICK_BITS-1:0] DIGIT_TICKS_RST   = 10'd100;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRIGGER_TICKS = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIGIT_TICKS   = 1'd1;

  // Seven-segment patterns, bit0 = a .. bit6 = g, dot off
  localparam logic [SEG_BITS-1:0] SEG_TABLE [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Commands from the phase sequencer to the range accumulator
  typedef struct packed {
    logic start;   // first high echo tick: count of one
    logic step;    // echo still high: one more tick
    logic latch;   // echo ended: capture distance and digits
  } range_cmd_t;

  // Captured measurement
  typedef struct packed {
    logic [DIGITS-1:0][3:0]  digits;    // BCD, index 0 = units
    logic [DIST_BITS-1:0]    distance;
  } range_t;

endpackage

// ----- rtl/urss_range.sv -----
// ----------------------------------------------------------------------------
// urss_range
// Echo tick counter with a running distance: keeps count*10 = 58*acc + rem
// and a BCD copy of acc, so no divider is needed when the echo ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ultrasonic_range_seven_segment_core_assert.svh"

module urss_range #(
  parameter int COUNT_BITS = urss_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step_en,
  input  urss_pkg::range_cmd_t cmd,
  output urss_pkg::range_t     range
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [6:0] CM_STEP = 7'd10;   // numerator gain per tick
  localparam logic [6:0] CM_DIV  = 7'd58;   // ticks of 10 us per cm, times 10
  localparam logic [urss_pkg::DIST_BITS-1:0] DIST_MAX = {urss_pkg::DIST_BITS{1'b1}};
  // Digits of the saturated distance 1023
  localparam logic [urss_pkg::DIGITS-1:0][3:0] DIGITS_MAX = {4'd1, 4'd0, 4'd2, 4'd3};

  logic [COUNT_BITS-1:0]               echo_count;
  logic [5:0]                          rem;
  logic [urss_pkg::DIST_BITS-1:0]      acc;
  logic                                over;
  logic [urss_pkg::DIGITS-1:0][3:0]    bcd;

  logic [6:0]                          rem_sum;
  logic                                carry_cm;
  logic [urss_pkg::DIGITS-1:0][3:0]    bcd_inc;

  // BCD increment, ripple over the digits
  function automatic logic [urss_pkg::DIGITS-1:0][3:0] bcd_plus1(
    input logic [urss_pkg::DIGITS-1:0][3:0] v
  );
    logic [urss_pkg::DIGITS-1:0][3:0] r;
    logic                             c;
    r = v;
    c = 1'b1;
    for (int i = 0; i < urss_pkg::DIGITS; i++) begin
      if (c) begin
        if (v[i] == 4'd9) begin
          r[i] = 4'd0;
        end else begin
          r[i] = v[i] + 4'd1;
          c    = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Next remainder and whole-centimeter carry
  always_comb begin
    rem_sum  = {1'b0, rem} + CM_STEP;
    carry_cm = (rem_sum >= CM_DIV);
    bcd_inc  = bcd_plus1(bcd);
  end

  // Running count and capture
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_count     <= '0;
      rem            <= '0;
      acc            <= '0;
      over           <= 1'b0;
      bcd            <= '0;
      range.distance <= '0;
      range.digits   <= '0;
    end else if (step_en) begin
      if (cmd.start) begin
        echo_count <= COUNT_BITS'(1);
        rem        <= CM_STEP[5:0];
        acc        <= '0;
        over       <= 1'b0;
        bcd        <= '0;
      end else if (cmd.step && (echo_count < COUNT_MAX)) begin
        echo_count <= echo_count + COUNT_BITS'(1);
        if (carry_cm) begin
          rem <= 6'(rem_sum - CM_DIV);
          if (acc == DIST_MAX) begin
            over <= 1'b1;
          end else if (!over) begin
            acc <= acc + 10'd1;
            bcd <= bcd_inc;
          end
        end else begin
          rem <= rem_sum[5:0];
        end
      end else if (cmd.latch) begin
        range.distance <= over ? DIST_MAX : acc;
        range.digits   <= over ? DIGITS_MAX : bcd;
      end
    end
  end

  `URSS_ASSERT(a_rem_below_div, clk, rst, rem < 6'd58)
  `URSS_ASSERT(a_digits_bcd, clk, rst, (range.digits[0] <= 4'd9) && (range.digits[1] <= 4'd9) && (range.digits[2] <= 4'd9) && (range.digits[3] <= 4'd9))

endmodule

// ----- rtl/urss_ctrl.sv -----
// ----------------------------------------------------------------------------
// urss_ctrl
// Phase sequencer: trigger pulse, echo wait and count, digit scan and serial
// send. Its registers are the result word of each tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ultrasonic_range_seven_segment_core_assert.svh"

module urss_ctrl (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step_en,
  input  logic                                 echo,
  input  logic [urss_pkg::TICK_BITS-1:0]       trigger_ticks,
  input  logic [urss_pkg::TICK_BITS-1:0]       digit_ticks,
  input  urss_pkg::range_t                     range,
  output urss_pkg::range_cmd_t                 cmd,
  output logic                                 trigger,
  output logic [urss_pkg::DIGITS-1:0]          digit_enable,
  output logic [urss_pkg::SEG_BITS-1:0]        segments,
  output logic                                 distance_valid,
  output logic [7:0]                           serial_byte
);

  typedef enum logic [2:0] {
    PH_TRIG  = 3'd0,
    PH_WAIT  = 3'd1,
    PH_COUNT = 3'd2,
    PH_SHOW  = 3'd3,
    PH_SEND  = 3'd4
  } phase_t;

  phase_t                          phase, phase_next;
  logic [urss_pkg::TICK_BITS-1:0]  tick_counter, tick_counter_next;
  logic [1:0]                      digit_index, digit_index_next;
  logic [urss_pkg::DIGITS-1:0]     enable_next;
  logic [urss_pkg::SEG_BITS-1:0]   segment_next;
  logic                            trigger_next;
  logic                            valid_next;
  logic [7:0]                      sbyte_next;
  logic [urss_pkg::TICK_BITS-1:0]  tick_inc;

  // Next state and result word for one tick
  always_comb begin
    phase_next        = phase;
    tick_counter_next = tick_counter;
    digit_index_next  = digit_index;
    enable_next       = digit_enable;
    segment_next      = segments;
    trigger_next      = 1'b0;
    valid_next        = 1'b0;
    sbyte_next        = 8'd0;
    cmd               = '0;
    tick_inc          = tick_counter + 10'd1;

    unique case (phase)
      PH_WAIT: begin
        if (echo) begin
          cmd.start  = 1'b1;
          phase_next = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (echo) begin
          cmd.step = 1'b1;
        end else begin
          cmd.latch         = 1'b1;
          digit_index_next  = 2'd0;
          tick_counter_next = '0;
          phase_next        = PH_SHOW;
        end
      end
      PH_SHOW: begin
        enable_next  = 4'b0001 << digit_index;
        segment_next = urss_pkg::SEG_TABLE[range.digits[digit_index]];
        if (tick_inc >= digit_ticks) begin
          tick_counter_next = '0;
          if (digit_index == 2'd3) begin
            phase_next = PH_SEND;
          end else begin
            digit_index_next = digit_index + 2'd1;
          end
        end else begin
          tick_counter_next = tick_inc;
        end
      end
      PH_SEND: begin
        valid_next        = 1'b1;
        sbyte_next        = range.distance[7:0];
        tick_counter_next = '0;
        phase_next        = PH_TRIG;
      end
      default: begin
        // trigger pulse; an unknown code restarts it
        trigger_next = 1'b1;
        if (phase != PH_TRIG) begin
          tick_inc = 10'd1;
        end
        if (tick_inc >= trigger_ticks) begin
          tick_counter_next = '0;
          phase_next        = PH_WAIT;
        end else begin
          tick_counter_next = tick_inc;
          phase_next        = PH_TRIG;
        end
      end
    endcase
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TRIG;
      tick_counter   <= '0;
      digit_index    <= '0;
      digit_enable   <= '0;
      segments       <= '0;
      trigger        <= 1'b0;
      distance_valid <= 1'b0;
      serial_byte    <= '0;
    end else if (step_en) begin
      phase          <= phase_next;
      tick_counter   <= tick_counter_next;
      digit_index    <= digit_index_next;
      digit_enable   <= enable_next;
      segments       <= segment_next;
      trigger        <= trigger_next;
      distance_valid <= valid_next;
      serial_byte    <= sbyte_next;
    end
  end

  `URSS_ASSERT_NEXT(a_send_to_trig, clk, rst, step_en && (phase == PH_SEND), phase == PH_TRIG)
  `URSS_ASSERT(a_show_only_scan, clk, rst, (phase == PH_SHOW) || (tick_counter == 10'd0) || (phase == PH_TRIG))

endmodule

// ----- rtl/ultrasonic_range_seven_segment_core.sv -----
// Ultrasonic ranging core with a four-digit seven-segment display. Every
// input word is one 10 us tick with the sampled echo level, and every tick
// returns one result word. A word enters each clock cycle while echo_stall
// is low: it passes an input register and then the phase sequencer's result
// registers, which are loaded when the output is not stalled. Throughput is
// set by the single state update per tick and is one word per cycle when the
// output does not stall. The measurement itself (trigger pulse, echo length,
// digit scan of digit_ticks ticks per digit, serial send) spans as many ticks
// as the sensor and the configuration dictate.
// ----------------------------------------------------------------------------
// ultrasonic_range_seven_segment_core
// Top level: handshakes, configuration registers, sequencer and accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ultrasonic_range_seven_segment_core_assert.svh"

module ultrasonic_range_seven_segment_core #(
  parameter int COUNT_BITS = urss_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [urss_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [urss_pkg::TICK_BITS-1:0]       cfg_data,
  // tick words
  input  logic                                 echo_valid,
  output logic                                 echo_stall,
  input  logic                                 echo,
  // result words
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic                                 trigger,
  output logic [urss_pkg::DIGITS-1:0]          digit_enable,
  output logic [urss_pkg::SEG_BITS-1:0]        segments,
  output logic [urss_pkg::DIST_BITS-1:0]       distance,
  output logic                                 distance_valid,
  output logic [7:0]                           serial_byte
);

  logic [urss_pkg::TICK_BITS-1:0] trigger_ticks;
  logic [urss_pkg::TICK_BITS-1:0] digit_ticks;
  logic                           in_full;
  logic                           echo_q;
  logic                           step_en;
  logic                           echo_take;
  urss_pkg::range_cmd_t           cmd;
  urss_pkg::range_t               range;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_ticks <= urss_pkg::TRIGGER_TICKS_RST;
      digit_ticks   <= urss_pkg::DIGIT_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        urss_pkg::REG_TRIGGER_TICKS: trigger_ticks <= cfg_data;
        urss_pkg::REG_DIGIT_TICKS:   digit_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: input register moves into the result registers when free
  assign step_en    = in_full && (!result_valid || !result_stall);
  assign echo_stall = in_full && !step_en;
  assign echo_take  = echo_valid && !echo_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      in_full <= echo_take || (in_full && !step_en);
      if (step_en) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (echo_take) begin
      echo_q <= echo;
    end
  end

  urss_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .step_en        (step_en),
    .echo           (echo_q),
    .trigger_ticks  (trigger_ticks),
    .digit_ticks    (digit_ticks),
    .range          (range),
    .cmd            (cmd),
    .trigger        (trigger),
    .digit_enable   (digit_enable),
    .segments       (segments),
    .distance_valid (distance_valid),
    .serial_byte    (serial_byte)
  );

  urss_range #(
    .COUNT_BITS (COUNT_BITS)
  ) u_range (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .cmd     (cmd),
    .range   (range)
  );

  assign distance = range.distance;

  `URSS_ASSERT(a_send_no_trigger, clk, rst, !(result_valid && distance_valid && trigger))
  `URSS_ASSERT(a_serial_idle_zero, clk, rst, distance_valid || (serial_byte == 8'd0))
  `URSS_ASSERT(a_enable_onehot0, clk, rst, $onehot0(digit_enable))

endmodule

// ----- bench/tb_ultrasonic_range_seven_segment_core.sv -----
// ----------------------------------------------------------------------------
// tb_ultrasonic_range_seven_segment_core
// Self-checking bench for the ultrasonic ranging core. Echo ticks are sent
// as whole trigger/echo/display measurements with random pulse lengths, plus
// noise and cut-short sequences. A cycle-level model of the sequencer
// predicts every result word, and each received word is checked field by
// field. Both handshakes idle at random, the receiver holds off once long
// enough to back up the input, and the tick registers are rewritten between
// phases, the extremes and mid-phase updates included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ultrasonic_range_seven_segment_core;

  import urss_pkg::*;

  localparam int COUNT_BITS  = COUNT_BITS_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_TICKS = 250;

  typedef enum logic [2:0] {
    PH_TRIG  = 3'd0,
    PH_WAIT  = 3'd1,
    PH_COUNT = 3'd2,
    PH_SHOW  = 3'd3,
    PH_SEND  = 3'd4
  } range_phase_e;

  typedef struct packed {
    logic                 trigger;
    logic [DIGITS-1:0]    digit_enable;
    logic [SEG_BITS-1:0]  segments;
    logic [DIST_BITS-1:0] distance;
    logic                 distance_valid;
    logic [7:0]           serial_byte;
  } reading_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [TICK_BITS-1:0]      cfg_data;
  logic                      echo_valid;
  logic                      echo_stall;
  logic                      echo;
  logic                      result_valid;
  logic                      result_stall;
  logic                      trigger;
  logic [DIGITS-1:0]         digit_enable;
  logic [SEG_BITS-1:0]       segments;
  logic [DIST_BITS-1:0]      distance;
  logic                      distance_valid;
  logic [7:0]                serial_byte;

  ultrasonic_range_seven_segment_core #(
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .echo_valid    (echo_valid),
    .echo_stall    (echo_stall),
    .echo          (echo),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .trigger       (trigger),
    .digit_enable  (digit_enable),
    .segments      (segments),
    .distance      (distance),
    .distance_valid(distance_valid),
    .serial_byte   (serial_byte)
  );

  // Sequencer model state and its copy of the tick registers
  range_phase_e          seq_phase;
  logic [TICK_BITS-1:0]  tick_cnt;
  logic [COUNT_BITS-1:0] echo_len;
  logic [DIST_BITS-1:0]  dist_q;
  logic [1:0]            digit_sel;
  logic [DIGITS-1:0]     en_q;
  logic [SEG_BITS-1:0]   seg_q;
  logic                  trig_q;
  logic [TICK_BITS-1:0]  trigger_ticks_q;
  logic [TICK_BITS-1:0]  digit_ticks_q;

  reading_t pending_readings[$];

  // Sender and receiver controls
  int  burst_left;
  bit  gaps_on;
  int  hold_ask;
  int  hold_left;
  int  rx_mode;
  int  rx_cycle;
  int  quiet_cycles;

  // Run statistics
  int  fail_count;
  int  ticks_sent;
  int  sensed_ticks;
  int  readings_checked;
  int  sends_seen;
  int  reg_writes;
  int  max_distance;

  reading_t got_word;
  reading_t want_word;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Decimal digit of a distance, position 0 = units
  function automatic int digit_at(input int value, input logic [1:0] pos);
    int divisor;
    case (pos)
      2'd0:    divisor = 1;
      2'd1:    divisor = 10;
      2'd2:    divisor = 100;
      default: divisor = 1000;
    endcase
    return (value / divisor) % 10;
  endfunction

  // One tick of the sequencer; queues the word it produces
  task automatic ranging_step(input logic e);
    reading_t r;
    int       d;
    r = '0;
    case (seq_phase)
      PH_WAIT: begin
        trig_q = 1'b0;
        if (e) begin
          echo_len  = COUNT_BITS'(1);
          seq_phase = PH_COUNT;
        end
      end
      PH_COUNT: begin
        trig_q = 1'b0;
        if (e) begin
          if (echo_len != {COUNT_BITS{1'b1}})
            echo_len = echo_len + 1'b1;
        end else begin
          d         = (int'(echo_len) * 10) / 58;
          dist_q    = (d > 1023) ? 10'd1023 : DIST_BITS'(d);
          digit_sel = 2'd0;
          tick_cnt  = '0;
          seq_phase = PH_SHOW;
          if (d > max_distance) max_distance = d;
        end
      end
      PH_SHOW: begin
        trig_q   = 1'b0;
        en_q     = DIGITS'(1) << digit_sel;
        seg_q    = SEG_TABLE[digit_at(int'(dist_q), digit_sel)];
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= digit_ticks_q) begin
          tick_cnt = '0;
          if (digit_sel == 2'd3)
            seq_phase = PH_SEND;
          else
            digit_sel = digit_sel + 1'b1;
        end
      end
      PH_SEND: begin
        trig_q           = 1'b0;
        r.distance_valid = 1'b1;
        r.serial_byte    = dist_q[7:0];
        tick_cnt         = '0;
        seq_phase        = PH_TRIG;
      end
      default: begin
        // trigger pulse; an unused code restarts it
        if (seq_phase != PH_TRIG) begin
          seq_phase = PH_TRIG;
          tick_cnt  = '0;
        end
        trig_q   = 1'b1;
        echo_len = '0;
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= trigger_ticks_q) begin
          tick_cnt  = '0;
          seq_phase = PH_WAIT;
        end
      end
    endcase
    r.trigger      = trig_q;
    r.digit_enable = en_q;
    r.segments     = seg_q;
    r.distance     = dist_q;
    pending_readings.push_back(r);
  endtask

  // Send one echo word; bursts of random length with random gaps between
  task automatic send_tick(input logic e);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (gaps_on && $urandom_range(0, 2) != 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        echo_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    echo_valid <= 1'b1;
    echo       <= e;
    @(posedge clk);
    while (echo_stall) @(posedge clk);
    if (seq_phase == PH_WAIT || seq_phase == PH_COUNT) sensed_ticks++;
    ticks_sent++;
    burst_left--;
    ranging_step(e);
  endtask

  // Stop sending and wait until every queued word has come back
  task automatic drain_readings();
    echo_valid <= 1'b0;
    burst_left = 0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // Write both tick registers back to back; block must be drained
  task automatic set_timing(input logic [TICK_BITS-1:0] trig_ticks,
                            input logic [TICK_BITS-1:0] dig_ticks);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TRIGGER_TICKS;
    cfg_data  <= trig_ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    trigger_ticks_q = trig_ticks;
    cfg_index <= REG_DIGIT_TICKS;
    cfg_data  <= dig_ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    digit_ticks_q = dig_ticks;
    cfg_valid <= 1'b0;
    reg_writes += 2;
  endtask

  // One measurement: noise until the wait phase, low ticks, an echo pulse,
  // then noise until the cycle restarts or show_stop ticks have passed
  task automatic measure(input int pre_low, input int pulse, input int show_stop);
    int n;
    n = 0;
    while (seq_phase != PH_WAIT) send_tick(1'($urandom_range(0, 1)));
    repeat (pre_low) send_tick(1'b0);
    repeat (pulse) send_tick(1'b1);
    send_tick(1'b0);
    while (seq_phase != PH_TRIG && (show_stop < 0 || n < show_stop)) begin
      send_tick(1'($urandom_range(0, 1)));
      n++;
    end
  endtask

  // Random pulse length, mostly short echoes, some far targets
  function automatic int pick_pulse();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 60);
    if (r < 9) return $urandom_range(61, 200);
    return $urandom_range(201, 400);
  endfunction

  // Random tick register value, small most of the time
  function automatic logic [TICK_BITS-1:0] pick_ticks();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r < 12) return TICK_BITS'($urandom_range(1, 6));
    if (r < 15) return TICK_BITS'($urandom_range(7, 40));
    return TICK_BITS'($urandom_range(41, 200));
  endfunction

  // Zero trigger register acting as one, first echo tick, distances 0 and 1
  task automatic test_short_pulses();
    set_timing('0, 10'd1);
    measure(2, 1, -1);
    measure(0, 6, -1);
    drain_readings();
  endtask

  // Tick registers lowered below the running tick count
  task automatic test_midphase_writes();
    set_timing(10'd200, 10'd100);
    repeat (50) send_tick(1'($urandom_range(0, 1)));
    drain_readings();
    set_timing(10'd10, 10'd100);
    measure(2, 12, 30);
    drain_readings();
    set_timing(10'd10, 10'd5);
    measure(1, 3, -1);
    drain_readings();
  endtask

  // Long echo: three-digit distance and many remainder carries
  task automatic test_long_echo();
    set_timing(10'd1, 10'd2);
    measure(0, 650, -1);
    drain_readings();
  endtask

  // Largest register values, then lowered while their phases are running
  task automatic test_slow_extremes();
    set_timing(10'd1023, 10'd1023);
    repeat (120) send_tick(1'($urandom_range(0, 1)));
    drain_readings();
    set_timing(10'd1, 10'd1023);
    measure(1, 20, 100);
    drain_readings();
    set_timing(10'd1, 10'd2);
    measure(0, 2, -1);
    drain_readings();
  endtask

  // Long receiver hold-off while the sender keeps offering words
  task automatic test_backpressure();
    int start;
    set_timing(10'd2, 10'd3);
    gaps_on  = 1'b0;
    hold_ask = HOLD_CYCLES;
    start    = ticks_sent;
    while (ticks_sent - start < 250) measure($urandom_range(0, 3), pick_pulse() % 40 + 1, -1);
    gaps_on = 1'b1;
    drain_readings();
  endtask

  // Random measurements under changing register settings
  task automatic test_random_ranging();
    int start;
    int phase_start;
    start = sensed_ticks;
    while (sensed_ticks - start < RANDOM_TICKS) begin
      set_timing(pick_ticks(), pick_ticks());
      phase_start = sensed_ticks;
      while (sensed_ticks - phase_start < 100 && sensed_ticks - start < RANDOM_TICKS) begin
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 10)) send_tick(1'($urandom_range(0, 1)));
        measure($urandom_range(0, 5), pick_pulse(), -1);
      end
      // sometimes leave the display mid-digit before the next write
      if ($urandom_range(0, 2) == 0)
        measure($urandom_range(0, 2), $urandom_range(1, 40), $urandom_range(0, 3));
      drain_readings();
    end
  endtask

  // Receiver stall pattern and result checking
  always @(posedge clk) begin
    rx_cycle++;
    if (hold_ask > 0) begin
      hold_left = hold_ask;
      hold_ask  = 0;
    end
    if (rx_cycle % 48 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      case (rx_mode)
        0:       result_stall <= 1'b0;
        1:       result_stall <= ($urandom_range(0, 3) == 0);
        2:       result_stall <= ($urandom_range(0, 3) != 0);
        default: result_stall <= rx_cycle[1];
      endcase
    end

    if (!rst && result_valid && !result_stall) begin
      got_word = '{trigger, digit_enable, segments, distance, distance_valid, serial_byte};
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got_word);
        fail_count++;
      end else begin
        want_word = pending_readings.pop_front();
        readings_checked++;
        if (want_word.distance_valid) sends_seen++;
        if (got_word.trigger !== want_word.trigger) begin
          $display("%0t: trigger expected %0h actual %0h", $time,
                   want_word.trigger, got_word.trigger);
          fail_count++;
        end
        if (got_word.digit_enable !== want_word.digit_enable) begin
          $display("%0t: digit_enable expected %0h actual %0h", $time,
                   want_word.digit_enable, got_word.digit_enable);
          fail_count++;
        end
        if (got_word.segments !== want_word.segments) begin
          $display("%0t: segments expected %0h actual %0h", $time,
                   want_word.segments, got_word.segments);
          fail_count++;
        end
        if (got_word.distance !== want_word.distance) begin
          $display("%0t: distance expected %0d actual %0d", $time,
                   want_word.distance, got_word.distance);
          fail_count++;
        end
        if (got_word.distance_valid !== want_word.distance_valid) begin
          $display("%0t: distance_valid expected %0h actual %0h", $time,
                   want_word.distance_valid, got_word.distance_valid);
          fail_count++;
        end
        if (got_word.serial_byte !== want_word.serial_byte) begin
          $display("%0t: serial_byte expected %0h actual %0h", $time,
                   want_word.serial_byte, got_word.serial_byte);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((echo_valid && !echo_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready) || rst)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d words outstanding", $time,
               quiet_cycles, pending_readings.size());
      $display("ultrasonic_range_seven_segment_core: mismatch");
      $finish;
    end
  end

  // Test sequence
  initial begin
    rst          <= 1'b1;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    echo_valid   <= 1'b0;
    echo         <= 1'b0;
    result_stall <= 1'b0;

    seq_phase       = PH_TRIG;
    tick_cnt        = '0;
    echo_len        = '0;
    dist_q          = '0;
    digit_sel       = '0;
    en_q            = '0;
    seg_q           = '0;
    trig_q          = 1'b0;
    trigger_ticks_q = TRIGGER_TICKS_RST;
    digit_ticks_q   = DIGIT_TICKS_RST;
    burst_left      = 0;
    gaps_on         = 1'b1;
    hold_ask        = 0;
    hold_left       = 0;
    rx_mode         = 0;
    rx_cycle        = 0;
    quiet_cycles    = 0;
    fail_count      = 0;
    ticks_sent      = 0;
    sensed_ticks    = 0;
    readings_checked = 0;
    sends_seen      = 0;
    reg_writes      = 0;
    max_distance    = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_pulses();
    test_midphase_writes();
    test_long_echo();
    test_slow_extremes();
    test_backpressure();
    test_random_ranging();

    drain_readings();
    repeat (8) @(posedge clk);

    $display("Sent %0d ticks, checked %0d words, %0d serial sends, %0d register writes",
             ticks_sent, readings_checked, sends_seen, reg_writes);
    $display("Largest distance %0d cm over short, long and cut-short echoes",
             max_distance);
    if (fail_count == 0 && pending_readings.size() == 0)
      $display("ultrasonic_range_seven_segment_core: match");
    else
      $display("ultrasonic_range_seven_segment_core: mismatch");
    $finish;
  end

endmodule
